[rtl/ptia_pkg.sv]
`timescale 1ns / 1ps
package ptia_pkg;

   typedef enum logic [2:0] {
      OP_READ  = 3'd0,
      OP_WRITE = 3'd1,
      OP_TICK  = 3'd2,
      OP_CA1   = 3'd3,
      OP_CB1   = 3'd4,
      OP_CB2   = 3'd5,
      OP_PB6   = 3'd6,
      OP_NONE  = 3'd7
   } op_type;

   localparam logic [3:0] REG_ORB       = 4'd0;
   localparam logic [3:0] REG_ORA       = 4'd1;
   localparam logic [3:0] REG_DIR_B     = 4'd2;
   localparam logic [3:0] REG_DIR_A     = 4'd3;
   localparam logic [3:0] REG_T1_CNT_LO = 4'd4;
   localparam logic [3:0] REG_T1_CNT_HI = 4'd5;
   localparam logic [3:0] REG_T1_LAT_LO = 4'd6;
   localparam logic [3:0] REG_T1_LAT_HI = 4'd7;
   localparam logic [3:0] REG_T2_CNT_LO = 4'd8;
   localparam logic [3:0] REG_T2_CNT_HI = 4'd9;
   localparam logic [3:0] REG_SR        = 4'd10;
   localparam logic [3:0] REG_ACR       = 4'd11;
   localparam logic [3:0] REG_PCR       = 4'd12;
   localparam logic [3:0] REG_IFR       = 4'd13;
   localparam logic [3:0] REG_IER       = 4'd14;
   localparam logic [3:0] REG_ORA_NH    = 4'd15;

   localparam logic [6:0] F_CA2 = 7'h01;
   localparam logic [6:0] F_CA1 = 7'h02;
   localparam logic [6:0] F_SR  = 7'h04;
   localparam logic [6:0] F_CB2 = 7'h08;
   localparam logic [6:0] F_CB1 = 7'h10;
   localparam logic [6:0] F_T2  = 7'h20;
   localparam logic [6:0] F_T1  = 7'h40;

   typedef struct packed {
      logic [2:0] operation;
      logic [3:0] reg_addr;
      logic [7:0] write_data;
      logic       line_level;
      logic [7:0] pins_a;
      logic [7:0] pins_b;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] port_a_out;
      logic [7:0] port_b_out;
      logic       irq_level;
      logic       irq_changed;
   } rsp_type;

endpackage

[rtl/io_port_timer_interface_adapter.sv]
`timescale 1ns / 1ps
// io port / timer interface adapter
// req channel: one transaction per bus read, bus write, clock tick,
// control-line level change or pb6 pulse (operation field selects which).
// rsp channel: exactly one transaction per request, in order, carrying the
// read byte, both port views, the irq level and an irq-changed flag.
// output: the result is registered, so it shows on rsp in the cycle after
// the request is taken.
// throughput: one request per cycle unless rsp stalls; all register updates
// are done in a single combinational pass from request to result register.
// req_ready is high whenever the result register is empty or is being
// drained in the same cycle, so a stalled receiver stops new requests only
// while its result is still held.
// reset: synchronous, clears all timers, flags and control registers,
// input latches go to all ones and the last control-line levels to one.
module io_port_timer_interface_adapter
   import ptia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    step;
   rsp_type result;

   assign req_ready = !rsp_valid || rsp_ready;
   assign step = req_valid && req_ready;

   ptia_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_data),
      .rsp   (result)
   );

   ptia_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .data_in   (result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/ptia_core.sv]
`timescale 1ns / 1ps
module ptia_core
   import ptia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   output rsp_type rsp
);

   logic [7:0]  ora_ff, ora_in, orb_ff, orb_in, ddra_ff, ddra_in, ddrb_ff, ddrb_in;
   logic [7:0]  lata_ff, lata_in, latb_ff, latb_in;
   logic [15:0] t1c_ff, t1c_in, t1l_ff, t1l_in, t2c_ff, t2c_in;
   logic        pb7_ff, pb7_in, t1rp_ff, t1rp_in, t1f_ff, t1f_in, t2f_ff, t2f_in;
   logic [7:0]  t2ll_ff, t2ll_in, sd_ff, sd_in, acr_ff, acr_in, pcr_ff, pcr_in;
   logic [3:0]  sbl_ff, sbl_in;
   logic [8:0]  sph_ff, sph_in;
   logic        srun_ff, srun_in;
   logic [6:0]  ifr_ff, ifr_in, ier_ff, ier_in;
   logic        ca1_ff, ca1_in, cb1_ff, cb1_in, cb2_ff, cb2_in, irql_ff, irql_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ora_ff <= '0; orb_ff <= '0; ddra_ff <= '0; ddrb_ff <= '0;
         lata_ff <= 8'hFF; latb_ff <= 8'hFF;
         t1c_ff <= '0; t1l_ff <= '0; t2c_ff <= '0;
         pb7_ff <= 1'b0; t1rp_ff <= 1'b0; t1f_ff <= 1'b0; t2f_ff <= 1'b0;
         t2ll_ff <= '0; sd_ff <= '0; acr_ff <= '0; pcr_ff <= '0;
         sbl_ff <= '0; sph_ff <= '0; srun_ff <= 1'b0;
         ifr_ff <= '0; ier_ff <= '0;
         ca1_ff <= 1'b1; cb1_ff <= 1'b1; cb2_ff <= 1'b1; irql_ff <= 1'b0;
      end else if (step) begin
         ora_ff <= ora_in; orb_ff <= orb_in; ddra_ff <= ddra_in; ddrb_ff <= ddrb_in;
         lata_ff <= lata_in; latb_ff <= latb_in;
         t1c_ff <= t1c_in; t1l_ff <= t1l_in; t2c_ff <= t2c_in;
         pb7_ff <= pb7_in; t1rp_ff <= t1rp_in; t1f_ff <= t1f_in; t2f_ff <= t2f_in;
         t2ll_ff <= t2ll_in; sd_ff <= sd_in; acr_ff <= acr_in; pcr_ff <= pcr_in;
         sbl_ff <= sbl_in; sph_ff <= sph_in; srun_ff <= srun_in;
         ifr_ff <= ifr_in; ier_ff <= ier_in;
         ca1_ff <= ca1_in; cb1_ff <= cb1_in; cb2_ff <= cb2_in; irql_ff <= irql_in;
      end
   end

   logic [7:0] view_a, view_b_raw, view_b, rd;
   logic [2:0] mode_old, mode;
   logic [9:0] period;
   logic [8:0] ph_next;
   logic       act, t2_dec, irq;

   assign view_a = acr_ff[0] ? lata_ff : ((ora_ff & ddra_ff) | (req.pins_a & ~ddra_ff));
   assign view_b_raw = acr_ff[1] ? latb_ff
                                 : ((orb_ff & ddrb_ff) | (req.pins_b & ~ddrb_ff));
   assign view_b = acr_ff[7] ? {pb7_ff, view_b_raw[6:0]} : view_b_raw;
   assign mode_old = acr_ff[4:2];

   always_comb begin
      ora_in = ora_ff; orb_in = orb_ff; ddra_in = ddra_ff; ddrb_in = ddrb_ff;
      lata_in = lata_ff; latb_in = latb_ff;
      t1c_in = t1c_ff; t1l_in = t1l_ff; t2c_in = t2c_ff;
      pb7_in = pb7_ff; t1rp_in = t1rp_ff; t1f_in = t1f_ff; t2f_in = t2f_ff;
      t2ll_in = t2ll_ff; sd_in = sd_ff; acr_in = acr_ff; pcr_in = pcr_ff;
      sbl_in = sbl_ff; sph_in = sph_ff; srun_in = srun_ff;
      ifr_in = ifr_ff; ier_in = ier_ff;
      ca1_in = ca1_ff; cb1_in = cb1_ff; cb2_in = cb2_ff;
      rd = '0; act = 1'b0; t2_dec = 1'b0; mode = 3'd0;
      period = 10'd2; ph_next = '0;
      unique case (op_type'(req.operation))
         OP_READ: begin
            unique case (req.reg_addr)
               REG_ORB: begin ifr_in = ifr_ff & ~(F_CB1 | F_CB2); rd = view_b; end
               REG_ORA: begin ifr_in = ifr_ff & ~(F_CA1 | F_CA2); rd = view_a; end
               REG_DIR_B: rd = ddrb_ff;
               REG_DIR_A: rd = ddra_ff;
               REG_T1_CNT_LO: begin ifr_in = ifr_ff & ~F_T1; rd = t1c_ff[7:0]; end
               REG_T1_CNT_HI: rd = t1c_ff[15:8];
               REG_T1_LAT_LO: rd = t1l_ff[7:0];
               REG_T1_LAT_HI: rd = t1l_ff[15:8];
               REG_T2_CNT_LO: begin ifr_in = ifr_ff & ~F_T2; rd = t2c_ff[7:0]; end
               REG_T2_CNT_HI: rd = t2c_ff[15:8];
               REG_SR: begin
                  ifr_in = ifr_ff & ~F_SR;
                  sbl_in = 4'd8;
                  srun_in = (mode_old != 3'd0);
                  rd = sd_ff;
               end
               REG_ACR: rd = acr_ff;
               REG_PCR: rd = pcr_ff;
               REG_IFR: rd = {|(ifr_ff & ier_ff), ifr_ff};
               REG_IER: rd = {1'b1, ier_ff};
               default: rd = view_a;
            endcase
         end
         OP_WRITE: begin
            unique case (req.reg_addr)
               REG_ORB: begin orb_in = req.write_data; ifr_in = ifr_ff & ~(F_CB1 | F_CB2); end
               REG_ORA: begin ora_in = req.write_data; ifr_in = ifr_ff & ~(F_CA1 | F_CA2); end
               REG_DIR_B: ddrb_in = req.write_data;
               REG_DIR_A: ddra_in = req.write_data;
               REG_T1_CNT_LO, REG_T1_LAT_LO: t1l_in = {t1l_ff[15:8], req.write_data};
               REG_T1_CNT_HI: begin
                  t1l_in = {req.write_data, t1l_ff[7:0]};
                  t1c_in = {req.write_data, t1l_ff[7:0]};
                  t1f_in = 1'b0; t1rp_in = 1'b0;
                  ifr_in = ifr_ff & ~F_T1;
                  if (acr_ff[7]) pb7_in = 1'b0;
               end
               REG_T1_LAT_HI: begin
                  t1l_in = {req.write_data, t1l_ff[7:0]};
                  ifr_in = ifr_ff & ~F_T1;
               end
               REG_T2_CNT_LO: t2ll_in = req.write_data;
               REG_T2_CNT_HI: begin
                  t2c_in = {req.write_data, t2ll_ff};
                  t2f_in = 1'b0;
                  ifr_in = ifr_ff & ~F_T2;
               end
               REG_SR: begin
                  sd_in = req.write_data; sbl_in = 4'd8; sph_in = '0;
                  srun_in = (mode_old != 3'd0);
               end
               REG_ACR: begin
                  acr_in = req.write_data;
                  srun_in = (req.write_data[4:2] != 3'd0) && (sbl_ff != 4'd0);
               end
               REG_PCR: pcr_in = req.write_data;
               REG_IFR: ifr_in = ifr_ff & ~req.write_data[6:0];
               REG_IER: ier_in = req.write_data[7] ? (ier_ff | req.write_data[6:0])
                                                   : (ier_ff & ~req.write_data[6:0]);
               default: ora_in = req.write_data;
            endcase
         end
         OP_TICK: begin
            if (t1rp_ff) begin
               t1c_in = t1l_ff; t1rp_in = 1'b0;
            end else if (t1c_ff == 16'd0) begin
               if (acr_ff[6]) begin
                  ifr_in = ifr_in | F_T1;
                  if (acr_ff[7]) pb7_in = ~pb7_ff;
                  t1rp_in = 1'b1;
               end else if (!t1f_ff) begin
                  ifr_in = ifr_in | F_T1;
                  t1f_in = 1'b1;
                  if (acr_ff[7]) pb7_in = 1'b1;
               end
               t1c_in = 16'hFFFF;
            end else begin
               t1c_in = t1c_ff - 16'd1;
            end
            t2_dec = !acr_ff[5];
            mode = mode_old;
            if (srun_ff && mode != 3'd0 && mode != 3'd3 && mode != 3'd7) begin
               if (mode == 3'd1 || mode == 3'd4 || mode == 3'd5)
                  period = {2'b00, t2ll_ff} + 10'd2;
               ph_next = sph_ff + 9'd1;
               if ({1'b0, ph_next} < period) begin
                  sph_in = ph_next;
               end else begin
                  sph_in = '0;
                  if (sbl_ff <= 4'd1) begin
                     ifr_in = ifr_in | F_SR;
                     if (mode == 3'd4) sbl_in = 4'd8;
                     else begin sbl_in = 4'd0; srun_in = 1'b0; end
                  end else begin
                     sbl_in = sbl_ff - 4'd1;
                  end
               end
            end
         end
         OP_CA1: begin
            act = pcr_ff[0] ? (req.line_level && !ca1_ff) : (!req.line_level && ca1_ff);
            ca1_in = req.line_level;
            if (act) begin
               if (acr_ff[0]) lata_in = req.pins_a;
               ifr_in = ifr_ff | F_CA1;
            end
         end
         OP_CB1: begin
            act = pcr_ff[4] ? (req.line_level && !cb1_ff) : (!req.line_level && cb1_ff);
            cb1_in = req.line_level;
            if (act) begin
               if (acr_ff[1]) latb_in = req.pins_b;
               ifr_in = ifr_ff | F_CB1;
               if ((mode_old == 3'd3 || mode_old == 3'd7) && srun_ff && sbl_ff != 4'd0) begin
                  sbl_in = sbl_ff - 4'd1;
                  if (sbl_ff == 4'd1) begin
                     ifr_in = ifr_ff | F_CB1 | F_SR;
                     srun_in = 1'b0;
                  end
               end
            end
         end
         OP_CB2: begin
            act = pcr_ff[6] ? (req.line_level && !cb2_ff) : (!req.line_level && cb2_ff);
            cb2_in = req.line_level;
            if (act && !pcr_ff[7]) ifr_in = ifr_ff | F_CB2;
         end
         OP_PB6: t2_dec = acr_ff[5];
         default: ;
      endcase
      if (t2_dec) begin
         if (t2c_ff == 16'd0) begin
            if (!t2f_ff) begin
               ifr_in = ifr_in | F_T2;
               t2f_in = 1'b1;
            end
            t2c_in = 16'hFFFF;
         end else begin
            t2c_in = t2c_ff - 16'd1;
         end
      end
   end

   // port views use the state after the item
   logic [7:0] na, nbr;
   assign na  = acr_in[0] ? lata_in : ((ora_in & ddra_in) | (req.pins_a & ~ddra_in));
   assign nbr = acr_in[1] ? latb_in : ((orb_in & ddrb_in) | (req.pins_b & ~ddrb_in));
   assign irq = |(ifr_in & ier_in);
   assign irql_in = irq;

   always_comb begin
      rsp.read_data   = rd;
      rsp.port_a_out  = na;
      rsp.port_b_out  = acr_in[7] ? {pb7_in, nbr[6:0]} : nbr;
      rsp.irq_level   = irq;
      rsp.irq_changed = irq ^ irql_ff;
   end

endmodule

[rtl/ptia_out_reg.sv]
`timescale 1ns / 1ps
module ptia_out_reg
   import ptia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type data_in,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic    valid_ff;
   rsp_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (load) valid_ff <= 1'b1;
      else if (rsp_ready) valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[rtl/ptia_checker.sv]
`timescale 1ns / 1ps
module ptia_checker
   import ptia_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // every accepted transaction yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("missing result");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");

   // read data is zero unless the item was a read
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.operation != OP_READ
      |=> rsp_data.read_data == 8'd0)
      else $error("nonzero read data");

   // ready while output register is free
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("stalled while empty");

endmodule

bind io_port_timer_interface_adapter ptia_checker u_ptia_checker (.*);
